### rtl/brre_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package brre_pkg;

    localparam int WORD_W       = 64;
    localparam int COL_W        = 12;
    localparam int COL_SPACE    = 1 << COL_W;
    localparam int RES_MAX      = 32;
    localparam int CNT_W        = $clog2(RES_MAX + 1);
    localparam int PAIRS        = WORD_W / 2;
    localparam int POS_W        = $clog2(PAIRS);
    localparam int QDEPTH       = 2;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);
    localparam int DEF_MAX_COLS = 4096;
    localparam int DEF_MAX_ROWS = 4096;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              line_end;
        logic [COL_W-1:0]  base;
        logic [COL_W-1:0]  row;
    } entry_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] res_count;
    } back_stat_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_stat_t;

endpackage

`default_nettype wire

### rtl/brre_front.sv
`timescale 1ns / 1ps
`default_nettype none

module brre_front #(
    parameter int MAX_COLS = brre_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = brre_pkg::DEF_MAX_ROWS
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [brre_pkg::WORD_W-1:0] pixel_word,
    input  wire logic                       row_end,
    input  wire logic                       image_end,
    input  wire brre_pkg::queue_stat_t      q_stat,
    output logic                            q_push,
    output brre_pkg::entry_t                q_entry
);

    localparam int COL_SPAN = (MAX_COLS > brre_pkg::COL_SPACE) ? brre_pkg::COL_SPACE : MAX_COLS;
    localparam int ROW_TOP  = (MAX_ROWS > brre_pkg::COL_SPACE) ? brre_pkg::COL_SPACE - 1
                                                               : MAX_ROWS - 1;

    logic [brre_pkg::COL_W-1:0] base_reg;
    logic [brre_pkg::COL_W-1:0] base_next;
    logic [brre_pkg::COL_W-1:0] row_reg;
    logic [brre_pkg::COL_W-1:0] row_next;
    logic [brre_pkg::COL_W:0]   base_step;
    logic                       line_end;

    assign in_ready  = !q_stat.full;
    assign q_push    = in_valid && in_ready;
    assign line_end  = row_end || image_end;
    assign base_step = {1'b0, base_reg} + (brre_pkg::COL_W + 1)'(brre_pkg::WORD_W);

    assign q_entry.word     = pixel_word;
    assign q_entry.line_end = line_end;
    assign q_entry.base     = base_reg;
    assign q_entry.row      = row_reg;

    always_comb
    begin
        base_next = base_reg;
        row_next  = row_reg;
        if (q_push)
        begin
            if (line_end)
            begin
                base_next = '0;
                if (image_end)
                begin
                    row_next = '0;
                end
                else if (row_reg < brre_pkg::COL_W'(ROW_TOP))
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            else if (base_step >= (brre_pkg::COL_W + 1)'(COL_SPAN))
            begin
                base_next = '0;
            end
            else
            begin
                base_next = base_step[brre_pkg::COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            row_reg  <= '0;
        end
        else
        begin
            base_reg <= base_next;
            row_reg  <= row_next;
        end
    end

endmodule

`default_nettype wire

### rtl/brre_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module brre_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire brre_pkg::entry_t      push_entry,
    input  wire logic                  pop,
    output brre_pkg::entry_t           head,
    output brre_pkg::queue_stat_t      stat
);

    brre_pkg::entry_t mem [brre_pkg::QDEPTH];

    logic [brre_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [brre_pkg::QPTR_W-1:0] wr_ptr_next;
    logic [brre_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [brre_pkg::QPTR_W-1:0] rd_ptr_next;
    logic [brre_pkg::QCNT_W-1:0] count_reg;
    logic [brre_pkg::QCNT_W-1:0] count_next;

    assign head           = mem[rd_ptr_reg];
    assign stat.full      = (count_reg == brre_pkg::QCNT_W'(brre_pkg::QDEPTH));
    assign stat.not_empty = (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == brre_pkg::QPTR_W'(brre_pkg::QDEPTH - 1)) ? '0
                                                                                 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == brre_pkg::QPTR_W'(brre_pkg::QDEPTH - 1)) ? '0
                                                                                 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### rtl/brre_back.sv
`timescale 1ns / 1ps
`default_nettype none

module brre_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire brre_pkg::queue_stat_t       q_stat,
    input  wire brre_pkg::entry_t            q_head,
    output logic                             q_pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [brre_pkg::COL_W-1:0]       run_row,
    output logic [brre_pkg::COL_W-1:0]       run_first,
    output logic [brre_pkg::COL_W-1:0]       run_last,
    output logic                             final_of_word,
    output brre_pkg::back_stat_t             stat
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_TAIL  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    localparam int CW = brre_pkg::COL_W;

    logic [1:0]                     state_reg, state_next;
    logic [brre_pkg::WORD_W-1:0]    sh_reg, sh_next;
    logic [CW-1:0]                  col_reg, col_next;
    logic [brre_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic [CW-1:0]                  base_reg, base_next;
    logic [CW-1:0]                  row_reg, row_next;
    logic                           line_end_reg, line_end_next;
    logic                           active_reg, active_next;
    logic [CW-1:0]                  start_reg, start_next;
    logic [brre_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic                           pend_valid_reg, pend_valid_next;
    logic [CW-1:0]                  pend_row_reg, pend_row_next;
    logic [CW-1:0]                  pend_first_reg, pend_first_next;
    logic [CW-1:0]                  pend_last_reg, pend_last_next;
    logic                           out_valid_reg, out_valid_next;
    logic [CW-1:0]                  out_row_reg, out_row_next;
    logic [CW-1:0]                  out_first_reg, out_first_next;
    logic [CW-1:0]                  out_last_reg, out_last_next;
    logic                           out_final_reg, out_final_next;

    logic          out_free;
    logic          pair_act;
    logic [CW-1:0] pair_start;
    logic          pair_hit;
    logic [CW-1:0] pair_first;
    logic [CW-1:0] pair_last;
    logic          hit;
    logic [CW-1:0] hit_first;
    logic [CW-1:0] hit_last;
    logic          keep;
    logic          go;

    assign out_valid     = out_valid_reg;
    assign run_row       = out_row_reg;
    assign run_first     = out_first_reg;
    assign run_last      = out_last_reg;
    assign final_of_word = out_final_reg;
    assign stat.busy      = (state_reg != ST_IDLE);
    assign stat.res_count = cnt_reg;

    assign out_free = !out_valid_reg || out_ready;

    // two columns per step; a pair can close at most one run
    always_comb
    begin
        pair_act   = active_reg;
        pair_start = start_reg;
        pair_hit   = 1'b0;
        pair_first = start_reg;
        pair_last  = col_reg;
        if (sh_reg[brre_pkg::WORD_W-1] && !pair_act)
        begin
            pair_act   = 1'b1;
            pair_start = col_reg;
        end
        else if (!sh_reg[brre_pkg::WORD_W-1] && pair_act)
        begin
            pair_hit   = 1'b1;
            pair_first = pair_start;
            pair_last  = col_reg - 1'b1;
            pair_act   = 1'b0;
        end
        if (sh_reg[brre_pkg::WORD_W-2] && !pair_act)
        begin
            pair_act   = 1'b1;
            pair_start = col_reg + 1'b1;
        end
        else if (!sh_reg[brre_pkg::WORD_W-2] && pair_act)
        begin
            pair_hit   = 1'b1;
            pair_first = pair_start;
            pair_last  = col_reg;
            pair_act   = 1'b0;
        end
    end

    always_comb
    begin
        hit       = 1'b0;
        hit_first = pair_first;
        hit_last  = pair_last;
        case (state_reg)
            ST_SCAN:
            begin
                hit = pair_hit;
            end
            ST_TAIL:
            begin
                hit       = active_reg && line_end_reg;
                hit_first = start_reg;
                hit_last  = base_reg + CW'(brre_pkg::WORD_W - 1);
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    assign keep = hit && (cnt_reg < brre_pkg::CNT_W'(brre_pkg::RES_MAX));
    assign go   = !(keep && pend_valid_reg) || out_free;

    always_comb
    begin
        state_next      = state_reg;
        sh_next         = sh_reg;
        col_next        = col_reg;
        pos_next        = pos_reg;
        base_next       = base_reg;
        row_next        = row_reg;
        line_end_next   = line_end_reg;
        active_next     = active_reg;
        start_next      = start_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_row_next   = pend_row_reg;
        pend_first_next = pend_first_reg;
        pend_last_next  = pend_last_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_row_next    = out_row_reg;
        out_first_next  = out_first_reg;
        out_last_next   = out_last_reg;
        out_final_next  = out_final_reg;
        q_pop           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_stat.not_empty)
                begin
                    q_pop         = 1'b1;
                    sh_next       = q_head.word;
                    col_next      = q_head.base;
                    base_next     = q_head.base;
                    row_next      = q_head.row;
                    line_end_next = q_head.line_end;
                    pos_next      = '0;
                    cnt_next      = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (go)
                begin
                    sh_next     = {sh_reg[brre_pkg::WORD_W-3:0], 2'b00};
                    col_next    = col_reg + CW'(2);
                    pos_next    = pos_reg + 1'b1;
                    active_next = pair_act;
                    start_next  = pair_start;
                    if (pos_reg == brre_pkg::POS_W'(brre_pkg::PAIRS - 1))
                    begin
                        state_next = ST_TAIL;
                    end
                end
            end
            ST_TAIL:
            begin
                if (go)
                begin
                    active_next = active_reg && !line_end_reg;
                    state_next  = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_row_next    = pend_row_reg;
                    out_first_next  = pend_first_reg;
                    out_last_next   = pend_last_reg;
                    out_final_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // hold the newest run back until the next one shows whether it is final
        if (keep && go)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_row_next   = pend_row_reg;
                out_first_next = pend_first_reg;
                out_last_next  = pend_last_reg;
                out_final_next = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_row_next   = row_reg;
            pend_first_next = hit_first;
            pend_last_next  = hit_last;
            cnt_next        = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            active_reg     <= 1'b0;
            start_reg      <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            start_reg      <= start_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg         <= sh_next;
        col_reg        <= col_next;
        pos_reg        <= pos_next;
        base_reg       <= base_next;
        row_reg        <= row_next;
        line_end_reg   <= line_end_next;
        pend_row_reg   <= pend_row_next;
        pend_first_reg <= pend_first_next;
        pend_last_reg  <= pend_last_next;
        out_row_reg    <= out_row_next;
        out_first_reg  <= out_first_next;
        out_last_reg   <= out_last_next;
        out_final_reg  <= out_final_next;
    end

endmodule

`default_nettype wire

### rtl/bitmap_row_run_extractor.sv
// Channel  Handshake             Payload
// input    in_valid / in_ready   pixel_word[63:0], row_end, image_end
// output   out_valid / out_ready run_row[11:0], run_first[11:0], run_last[11:0], final_of_word
//
// In the run scanner each word is loaded from the queue, then scanned in 32 steps of two
// columns each, followed by the row-end close and the release of the last run.
// Words are queued two deep ahead of the scanner; in_ready drops only when the queue is full.
// A full output register stalls the scan step that finds the next run.
// Reset clears row and column counters, the open run, the queue and both output stages.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_row_run_extractor #(
    parameter int MAX_COLS = brre_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = brre_pkg::DEF_MAX_ROWS
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [brre_pkg::WORD_W-1:0] pixel_word,
    input  wire logic                        row_end,
    input  wire logic                        image_end,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [brre_pkg::COL_W-1:0]       run_row,
    output logic [brre_pkg::COL_W-1:0]       run_first,
    output logic [brre_pkg::COL_W-1:0]       run_last,
    output logic                             final_of_word
);

    logic                  q_push;
    logic                  q_pop;
    brre_pkg::entry_t      q_entry;
    brre_pkg::entry_t      q_head;
    brre_pkg::queue_stat_t q_stat;
    brre_pkg::back_stat_t  b_stat;

    brre_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel_word (pixel_word),
        .row_end    (row_end),
        .image_end  (image_end),
        .q_stat     (q_stat),
        .q_push     (q_push),
        .q_entry    (q_entry)
    );

    brre_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .stat       (q_stat)
    );

    brre_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_stat        (q_stat),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .run_row       (run_row),
        .run_first     (run_first),
        .run_last      (run_last),
        .final_of_word (final_of_word),
        .stat          (b_stat)
    );

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("push into full queue");

    a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_stat.not_empty)
        else $error("pop from empty queue");

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        (!b_stat.busy && q_stat.not_empty) |=> b_stat.busy)
        else $error("scanner idle with queued word");

    a_budget: assert property (@(posedge clk) disable iff (!rst_n)
        b_stat.res_count <= brre_pkg::CNT_W'(brre_pkg::RES_MAX))
        else $error("run count over budget");

endmodule

`default_nettype wire
